/* rtl/core/tfcd_pkg.sv */
// ----------------------------------------------------------------------------
// Tone frequency command decoder package
// Shared constants, register indexes, phase codes and the result type.
// ----------------------------------------------------------------------------
package tfcd_pkg;

  // Configuration port geometry.
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int NUM_REGS    = 8;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_ONE     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_TWO     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_THREE   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_FOUR    = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_FIVE    = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH   = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_THR = 8'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FREQ     = 8'd7;

  // Register reset values, in index order.
  localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
    16'd4200, 16'd4400, 16'd4600, 16'd4800, 16'd5000, 16'd50, 16'd2000, 16'd12000
  };

  // Count to frequency conversion.
  localparam int COUNT_W      = 16;
  localparam int HZ_PER_COUNT = 20;
  localparam int PROD_W       = 21;   // 16-bit count times 20 fits in 21 bits
  localparam int AGREE_TOL    = 50;   // second window must agree within +/-50 Hz

  // Command encoding.
  localparam int CMD_W     = 3;
  localparam int NUM_BANDS = 5;
  localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;

  // Output frequency width.
  localparam int HELD_W = 16;

  // Window phase codes inside a measurement group.
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  // One result request.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [HELD_W-1:0] held_freq;
  } result_t;

endpackage

/* rtl/core/tone_frequency_command_decoder_unit.sv */
// ----------------------------------------------------------------------------
// Tone frequency command decoder
// Turns gate-window pulse counts into tone measurements and band commands.
// ----------------------------------------------------------------------------
// The block takes one window count per clock cycle while in_stall is low. Each
// count is scaled to Hz, grouped into measurements of two or three windows, and
// a held tone is classified into a command 0..5 when the tone drops to or below
// the presence threshold. The whole update is one pass of logic from the input
// port into the state and result registers, so a result request goes to the
// result register, or to the skid register if the output stalls. A two-entry
// output stage (result plus skid register) lets counts keep flowing while a
// result waits; in_stall rises only when both entries are full, and it comes
// from a flop. Configuration writes should be made while no result is pending.
module tone_frequency_command_decoder_unit #(
  parameter int FREQ_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [tfcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tfcd_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tfcd_pkg::COUNT_W-1:0]         window_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tfcd_pkg::CMD_W-1:0]           command,
  output logic [tfcd_pkg::HELD_W-1:0]          held_freq
);

  // Widths for saturation and for compares against 16-bit registers.
  localparam int SAT_W = (FREQ_WIDTH > tfcd_pkg::PROD_W) ? FREQ_WIDTH : tfcd_pkg::PROD_W;
  localparam int MAX_W = (FREQ_WIDTH > tfcd_pkg::CFG_W) ? FREQ_WIDTH : tfcd_pkg::CFG_W;
  localparam int CMP_W = MAX_W + 1;

  // Configuration registers.
  logic [tfcd_pkg::CFG_W-1:0] cfg_regs [tfcd_pkg::NUM_REGS];

  // Measurement state.
  logic [1:0]            window_phase;
  logic [FREQ_WIDTH-1:0] first_freq;
  logic [FREQ_WIDTH-1:0] tone_freq;

  // Next-state values.
  logic [1:0]            window_phase_next;
  logic [FREQ_WIDTH-1:0] first_freq_next;
  logic [FREQ_WIDTH-1:0] tone_freq_next;

  // Output stage.
  logic                 skid_valid;
  tfcd_pkg::result_t    out_data;
  tfcd_pkg::result_t    skid_data;
  tfcd_pkg::result_t    res_data;
  logic                 res_valid;

  // Datapath signals.
  logic                      accept;
  logic [tfcd_pkg::PROD_W-1:0] prod;
  logic [SAT_W-1:0]          prod_ext;
  logic [SAT_W-1:0]          sat_max;
  logic [FREQ_WIDTH-1:0]     freq;
  logic [FREQ_WIDTH-1:0]     diff;
  logic                      done;
  logic [FREQ_WIDTH-1:0]     meas;
  logic [FREQ_WIDTH-1:0]     meas_lim;
  logic                      present;
  logic [tfcd_pkg::NUM_BANDS-1:0] band_hit;
  logic [tfcd_pkg::CMD_W-1:0]     cmd;
  logic [CMP_W-1:0]          tone_cmp;
  logic [CMP_W-1:0]          half_cmp;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid;

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tfcd_pkg::NUM_REGS; i++) begin
        cfg_regs[i] <= tfcd_pkg::CFG_RESET[i];
      end
    end else if (cfg_write && (cfg_index < tfcd_pkg::CFG_INDEX_W'(tfcd_pkg::NUM_REGS))) begin
      cfg_regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Count to Hz with saturation at the frequency width.
  always_comb begin
    prod     = tfcd_pkg::PROD_W'(window_count) * tfcd_pkg::PROD_W'(tfcd_pkg::HZ_PER_COUNT);
    prod_ext = SAT_W'(prod);
    sat_max  = SAT_W'({FREQ_WIDTH{1'b1}});
    freq     = (prod_ext > sat_max) ? sat_max[FREQ_WIDTH-1:0] : prod_ext[FREQ_WIDTH-1:0];
    diff     = (freq > first_freq) ? (freq - first_freq) : (first_freq - freq);
  end

  // Window grouping: agreement check on the second window, third is ignored.
  always_comb begin
    window_phase_next = window_phase;
    first_freq_next   = first_freq;
    done              = 1'b0;
    meas              = '0;
    case (window_phase)
      tfcd_pkg::PHASE_SECOND: begin
        if (diff > FREQ_WIDTH'(tfcd_pkg::AGREE_TOL)) begin
          done              = 1'b1;
          window_phase_next = tfcd_pkg::PHASE_FIRST;
        end else begin
          window_phase_next = tfcd_pkg::PHASE_THIRD;
        end
      end
      tfcd_pkg::PHASE_THIRD: begin
        meas              = first_freq;
        done              = 1'b1;
        window_phase_next = tfcd_pkg::PHASE_FIRST;
      end
      default: begin
        first_freq_next   = freq;
        window_phase_next = tfcd_pkg::PHASE_SECOND;
      end
    endcase
  end

  // Range limit and presence test on a finished measurement.
  always_comb begin
    meas_lim = (CMP_W'(meas) > CMP_W'(cfg_regs[tfcd_pkg::REG_MAX_FREQ[2:0]])) ? '0 : meas;
    present  = CMP_W'(meas_lim) > CMP_W'(cfg_regs[tfcd_pkg::REG_PRESENCE_THR[2:0]]);
  end

  // Band classification of the held tone: strict window, no wrap.
  always_comb begin
    tone_cmp = CMP_W'(tone_freq);
    half_cmp = CMP_W'(cfg_regs[tfcd_pkg::REG_HALF_WIDTH[2:0]]);
    for (int b = 0; b < tfcd_pkg::NUM_BANDS; b++) begin
      band_hit[b] = ((tone_cmp + half_cmp) > CMP_W'(cfg_regs[b])) &&
                    (tone_cmp < (CMP_W'(cfg_regs[b]) + half_cmp));
    end
    cmd = tfcd_pkg::CMD_NONE;
    for (int b = tfcd_pkg::NUM_BANDS - 1; b >= 0; b--) begin
      if (band_hit[b]) begin
        cmd = tfcd_pkg::CMD_W'(b + 1);
      end
    end
  end

  // Held tone update and result request.
  always_comb begin
    tone_freq_next     = tone_freq;
    res_valid          = 1'b0;
    res_data.command   = cmd;
    res_data.held_freq = tfcd_pkg::HELD_W'(tone_freq);
    if (done) begin
      if (present) begin
        tone_freq_next = meas_lim;
      end else begin
        tone_freq_next = '0;
        res_valid      = accept;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_phase <= tfcd_pkg::PHASE_FIRST;
      first_freq   <= '0;
      tone_freq    <= '0;
    end else if (accept) begin
      window_phase <= window_phase_next;
      first_freq   <= first_freq_next;
      tone_freq    <= tone_freq_next;
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
        out_data  <= res_data;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
      skid_data  <= res_data;
    end
  end

  assign command   = out_data.command;
  assign held_freq = out_data.held_freq;

endmodule
